// ----- hdl/sdbm_pkg.sv -----
// shared constants and codes of the sparse disk block map translator
`default_nettype none

package sdbm_pkg;

	// map geometry, sector size and field widths
	localparam int MAP_ENTRIES  = 4096;
	localparam int SECTOR_BYTES = 512;
	localparam int MAP_AW       = $clog2(MAP_ENTRIES);
	localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
	localparam int COUNT_W      = MAP_AW + 1;
	localparam int OFFSET_W     = 48;
	localparam int WORD_W       = 32;
	localparam int SPB_W        = 16;

	localparam logic [WORD_W-1:0]  UNALLOCATED = 32'hffff_ffff;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
	localparam logic [SPB_W-1:0]   SPB_RESET   = 16'd2048;

	// request modes
	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_WRITE  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_ACCESS = 3'd0;
	localparam logic [2:0] ST_ZFILL  = 3'd1;
	localparam logic [2:0] ST_SKIP   = 3'd2;
	localparam logic [2:0] ST_ALLOC  = 3'd3;
	localparam logic [2:0] ST_OOR    = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_DATA_OFFSET   = 2'd0;
	localparam logic [1:0] CFG_MAP_OFFSET    = 2'd1;
	localparam logic [1:0] CFG_TOTAL_SECTORS = 2'd2;
	localparam logic [1:0] CFG_SPB           = 2'd3;

endpackage

`default_nettype wire

// ----- hdl/sdbm_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module sdbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/sdbm_div.sv -----
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module sdbm_div
	import sdbm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WORD_W-1:0] dividend,
	input  wire logic [SPB_W-1:0]  divisor,
	output logic                   done,
	output logic      [WORD_W-1:0] quotient,
	output logic      [SPB_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] quo_q;
	logic [SPB_W-1:0]  rem_q;
	logic [SPB_W-1:0]  div_q;
	logic [SPB_W:0]    trial;
	logic              ge;
	logic [SPB_W:0]    diff;

	// one shift and subtract step
	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WORD_W-2:0], ge};
			rem_q <= ge ? diff[SPB_W-1:0] : trial[SPB_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ----- hdl/sparse_disk_block_map_translator.sv -----
// sparse disk block map translator: sequencer, map memory and offset datapath
//
// Usage: the input channel (in_valid/in_stall) carries one request per
// sector: a map load (mode 0), a read (mode 1) or a write (mode 2). The
// output channel (out_valid/out_stall) returns exactly one result per
// request: status, byte offset, map entry address, new block number,
// allocated block count and the request-done flag.
// Configuration registers (cfg_we/cfg_index/cfg_data) must be written only
// while no request is in flight; the block itself does not enforce it.
// Sequence: a load, an unused mode or a range fault found at entry goes
// from idle to the done state and from there into the output register.
// A read or write runs the 32-step serial divider that splits the sector
// number into block and offset, then the map lookup (read and entry
// states), then one multiply and two add stages and the output register.
// A block past the end of the map is found after the divide.
// One request is worked on at a time; in_stall is high while it is in
// progress.
// The output register frees the sequencer: a new request is taken while a
// result still waits under out_stall, and that request waits in its final
// step until the output register is free.
// Reset clears the allocated count, the configuration (sectors per block
// back to 2048) and the output valid. The map memory is not cleared; each
// entry must be loaded before it is looked up.
`default_nettype none

module sparse_disk_block_map_translator
	import sdbm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [WORD_W-1:0]   cfg_data,
	// request channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          mode,
	input  wire logic [WORD_W-1:0]   sector_index,
	input  wire logic [MAP_AW-1:0]   map_index,
	input  wire logic [WORD_W-1:0]   map_value,
	input  wire logic                sector_is_zero,
	input  wire logic                last_of_request,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [2:0]          status,
	output logic      [OFFSET_W-1:0] byte_offset,
	output logic      [OFFSET_W-1:0] map_entry_address,
	output logic      [MAP_AW-1:0]   new_block_number,
	output logic      [COUNT_W-1:0]  allocated_total,
	output logic                     request_done
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_ENTRY = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_ADD   = 3'd5;
	localparam logic [2:0] S_SHIFT = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]          state_q;
	logic [COUNT_W-1:0]  count_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   data_off_q;
	logic [WORD_W-1:0]   map_off_q;
	logic [WORD_W-1:0]   total_q;
	logic [SPB_W-1:0]    spb_q;

	logic [1:0]          mode_q;
	logic                zero_q;
	logic [MAP_AW-1:0]   blk_q;
	logic [WORD_W-1:0]   oper_q;
	logic [OFFSET_W-1:0] prod_q;
	logic [OFFSET_W-1:0] sum_q;
	logic [2:0]          res_status_q;
	logic [OFFSET_W-1:0] res_off_q;
	logic [OFFSET_W-1:0] res_maddr_q;
	logic [MAP_AW-1:0]   res_newblk_q;
	logic                res_done_q;

	logic [2:0]          out_status_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic [OFFSET_W-1:0] out_maddr_q;
	logic [MAP_AW-1:0]   out_newblk_q;
	logic [COUNT_W-1:0]  out_total_q;
	logic                out_done_q;

	logic                accept;
	logic                is_rw;
	logic                range_bad;
	logic                load_counts;
	logic                div_done;
	logic [WORD_W-1:0]   div_quo;
	logic [SPB_W-1:0]    div_rem;
	logic                quo_big;
	logic [WORD_W-1:0]   entry;
	logic                entry_alloc;
	logic                map_full;
	logic                alloc_go;
	logic                out_free;
	logic                ram_we;
	logic [MAP_AW-1:0]   ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;

	// request decode
	assign in_stall    = state_q != S_IDLE;
	assign accept      = in_valid && !in_stall;
	assign is_rw       = (mode == MODE_READ) || (mode == MODE_WRITE);
	assign range_bad   = (spb_q == '0) || (sector_index >= total_q);
	assign load_counts = (map_value != UNALLOCATED) && (count_q != COUNT_MAX);
	assign quo_big     = div_quo >= WORD_W'(MAP_ENTRIES);
	assign entry_alloc = entry != UNALLOCATED;
	assign map_full    = count_q >= COUNT_W'(MAP_ENTRIES);
	assign alloc_go    = (state_q == S_ENTRY) && !entry_alloc && (mode_q == MODE_WRITE)
		&& !zero_q && !map_full;
	assign out_free    = !out_valid_q || !out_stall;

	// map memory write: loads at accept, allocations at lookup
	assign ram_we    = (accept && (mode == MODE_LOAD)) || alloc_go;
	assign ram_waddr = alloc_go ? blk_q : map_index;
	assign ram_wdata = alloc_go ? WORD_W'(count_q) : map_value;

	sdbm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAP_ENTRIES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (blk_q),
		.rdata (entry)
	);

	sdbm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && is_rw && !range_bad),
		.dividend  (sector_index),
		.divisor   (spb_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// sequencer, allocated count, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			data_off_q  <= '0;
			map_off_q   <= '0;
			total_q     <= '0;
			spb_q       <= SPB_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DATA_OFFSET:   data_off_q <= cfg_data;
					CFG_MAP_OFFSET:    map_off_q  <= cfg_data;
					CFG_TOTAL_SECTORS: total_q    <= cfg_data;
					CFG_SPB:           spb_q      <= cfg_data[SPB_W-1:0];
					default:           ;
				endcase
			end
			// a finished request fills the output, a taken result empties it
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == MODE_LOAD && load_counts) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= (is_rw && !range_bad) ? S_DIV : S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= quo_big ? S_DONE : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_ENTRY;
				end
				S_ENTRY: begin
					if (alloc_go) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= (entry_alloc || alloc_go) ? S_MUL : S_DONE;
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers of the current request
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q       <= mode;
					zero_q       <= sector_is_zero;
					res_off_q    <= '0;
					res_maddr_q  <= '0;
					res_newblk_q <= '0;
					// a range fault closes the request
					res_status_q <= (is_rw && range_bad) ? ST_OOR : ST_ACCESS;
					res_done_q   <= (is_rw && range_bad) || last_of_request;
				end
			end
			S_DIV: begin
				if (div_done) begin
					blk_q <= div_quo[MAP_AW-1:0];
					if (quo_big) begin
						res_status_q <= ST_OOR;
						res_done_q   <= 1'b1;
					end
				end
			end
			S_ENTRY: begin
				if (entry_alloc) begin
					oper_q       <= entry;
					res_status_q <= ST_ACCESS;
				end else if (mode_q == MODE_READ) begin
					res_status_q <= ST_ZFILL;
				end else if (zero_q) begin
					res_status_q <= ST_SKIP;
				end else if (map_full) begin
					res_status_q <= ST_OOR;
					res_done_q   <= 1'b1;
				end else begin
					oper_q       <= WORD_W'(count_q);
					res_status_q <= ST_ALLOC;
					res_newblk_q <= count_q[MAP_AW-1:0];
					res_maddr_q  <= OFFSET_W'(map_off_q) + OFFSET_W'({blk_q, 2'b00});
				end
			end
			// block times sectors per block
			S_MUL: begin
				prod_q <= OFFSET_W'(oper_q) * OFFSET_W'(spb_q);
			end
			// plus sector within block
			S_ADD: begin
				sum_q <= prod_q + OFFSET_W'(div_rem);
			end
			// scale to bytes and add data base
			S_SHIFT: begin
				res_off_q <= OFFSET_W'(data_off_q)
					+ {sum_q[OFFSET_W-1-SECTOR_SHIFT:0], {SECTOR_SHIFT{1'b0}}};
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_off_q    <= res_off_q;
			out_maddr_q  <= res_maddr_q;
			out_newblk_q <= res_newblk_q;
			out_total_q  <= count_q;
			out_done_q   <= res_done_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign byte_offset       = out_off_q;
	assign map_entry_address = out_maddr_q;
	assign new_block_number  = out_newblk_q;
	assign allocated_total   = out_total_q;
	assign request_done      = out_done_q;

endmodule

`default_nettype wire

// ----- hdl/sdbm_chk.sv -----
// port-level checker of the sparse disk block map translator and its bind
`default_nettype none

module sdbm_chk
	import sdbm_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [2:0]         status,
	input wire logic [MAP_AW-1:0]  new_block_number,
	input wire logic [COUNT_W-1:0] allocated_total,
	input wire logic               request_done
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one request at a time: busy right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in progress");

	// a fault always closes the request
	a_oor_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OOR |-> request_done)
		else $error("out of range result without request done");

	// a fresh block is the count before allocation
	a_alloc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ALLOC
			|-> allocated_total == COUNT_W'(new_block_number) + 1'b1)
		else $error("allocated block number does not match count");

	// status codes stay in the defined set
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_ACCESS || status == ST_ZFILL || status == ST_SKIP
			|| status == ST_ALLOC || status == ST_OOR))
		else $error("undefined status code");

endmodule

bind sparse_disk_block_map_translator sdbm_chk u_sdbm_chk (.*);

`default_nettype wire
